### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'd10;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_BACK,
        CUR_RETURN,
        CUR_ADVANCE,
        CUR_NEWLINE
    } t_cur_op;

    typedef struct packed {
        logic at_last_row;
        logic at_last_col;
    } t_cur_flags;

endpackage

### rtl/tcw_ram.sv
// Generic RAM with one write port and one registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/tcw_cursor.sv
// Cursor row, column and linear position registers with their update rules.
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int CELLS = ROWS * COLUMNS,
    localparam int AW = $clog2(CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_cur_op    i_op,
    output logic [AW-1:0]       o_lin,
    output tcw_pkg::t_cur_flags o_flags
);
    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [AW-1:0] BOTTOM_LIN = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_lin, n_lin;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_lin = r_lin;
        unique case (i_op)
            CUR_HOLD: begin
            end
            CUR_HOME: begin
                n_row = '0;
                n_col = '0;
                n_lin = '0;
            end
            CUR_BACK: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                    n_lin = r_lin - 1'b1;
                end
            end
            CUR_RETURN: begin
                n_col = '0;
                n_lin = r_lin - AW'(r_col);
            end
            CUR_NEWLINE: begin
                n_col = '0;
                if (r_row == LAST_ROW) begin
                    n_lin = BOTTOM_LIN;
                end else begin
                    n_row = r_row + 1'b1;
                    n_lin = r_lin - AW'(r_col) + COLS_A;
                end
            end
            CUR_ADVANCE: begin
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_lin = BOTTOM_LIN;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_lin = r_lin + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    n_lin = r_lin + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_lin <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_lin <= n_lin;
        end
    end

    assign o_lin = r_lin;
    assign o_flags.at_last_row = (r_row == LAST_ROW);
    assign o_flags.at_last_col = (r_col == LAST_COL);

endmodule

### rtl/text_console_writer_unit.sv
// Text console writer top level: command sequencer, screen memory and result register.
// A put passes through S_EXEC and then S_RESULT, where the result is registered; a read adds S_READ between them.
// A scroll adds row moves (S_SCROLL) then a blank fill of the bottom row (S_FILL); a clear runs S_FILL over every cell.
// One item is worked at a time; the next is taken in the cycle after the result is registered.
// The sweeps go through the single write port of the screen memory, one cell per cycle.
// Reset homes the cursor and sets the attribute to 10; screen contents are undefined until a clear.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_position,
    output logic [15:0] o_cell_value,
    output logic        o_scrolled,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW = $clog2(CELLS);
    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_MOVE = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_mode;
    logic [7:0]    r_char;
    logic [10:0]   r_cell;
    logic [7:0]    r_attr;
    logic [AW-1:0] r_sweep, n_sweep;
    logic          r_scrolled, n_scrolled;
    logic [15:0]   r_value, n_value;
    logic          r_out_valid, n_out_valid;
    logic [10:0]   r_out_pos;
    logic [15:0]   r_out_value;
    logic          r_out_scrolled;

    t_cur_op       cur_op;
    t_cur_flags    cur_flags;
    logic [AW-1:0] cur_lin;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    logic          in_accept;
    logic          out_load;

    assign in_accept = i_in_valid && r_state == S_IDLE;
    assign out_load = r_state == S_RESULT && (!r_out_valid || !i_out_stall);

    tcw_cursor #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_cursor (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_op(cur_op),
        .o_lin(cur_lin),
        .o_flags(cur_flags)
    );

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk(i_clk),
        .i_wr_en(wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en(rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_scrolled = r_scrolled;
        n_value = r_value;
        cur_op = CUR_HOLD;
        wr_en = 1'b0;
        wr_addr = cur_lin;
        wr_data = {r_attr, r_char};
        rd_en = 1'b0;
        rd_addr = COLS_A;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                    n_scrolled = 1'b0;
                    n_value = '0;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                n_sweep = '0;
                priority if (r_mode == MODE_PUT) begin
                    priority if (r_char == CHAR_BACKSPACE) begin
                        cur_op = CUR_BACK;
                    end else if (r_char == CHAR_RETURN) begin
                        cur_op = CUR_RETURN;
                    end else if (r_char == CHAR_NEWLINE) begin
                        cur_op = CUR_NEWLINE;
                        if (cur_flags.at_last_row) begin
                            n_state = S_SCROLL;
                            n_scrolled = 1'b1;
                            rd_en = 1'b1;
                        end
                    end else if (r_char >= CHAR_BLANK) begin
                        cur_op = CUR_ADVANCE;
                        wr_en = 1'b1;
                        if (cur_flags.at_last_row && cur_flags.at_last_col) begin
                            n_state = S_SCROLL;
                            n_scrolled = 1'b1;
                            rd_en = 1'b1;
                        end
                    end else begin
                        cur_op = CUR_HOLD;
                    end
                end else if (r_mode == MODE_READ) begin
                    if (32'(r_cell) < CELLS) begin
                        rd_en = 1'b1;
                        rd_addr = AW'(r_cell);
                        n_state = S_READ;
                    end
                end else if (r_mode == MODE_CLEAR) begin
                    cur_op = CUR_HOME;
                    n_state = S_FILL;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                n_value = rd_data;
                n_state = S_RESULT;
            end
            S_SCROLL: begin
                wr_en = 1'b1;
                wr_addr = r_sweep;
                wr_data = rd_data;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_MOVE) begin
                    n_state = S_FILL;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = r_sweep + 1'b1 + COLS_A;
                end
            end
            S_FILL: begin
                wr_en = 1'b1;
                wr_addr = r_sweep;
                wr_data = {r_attr, CHAR_BLANK};
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_CELL) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_attr <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep <= n_sweep;
        r_scrolled <= n_scrolled;
        r_value <= n_value;
        if (in_accept) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_cell <= i_cell_index;
        end
        if (out_load) begin
            r_out_pos <= 11'(cur_lin);
            r_out_value <= r_value;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_in_stall = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_value = r_out_value;
    assign o_scrolled = r_out_scrolled;

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(cur_lin) < CELLS)
        else $error("Cursor position left the screen.");

    a_scroll_homes_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_scrolled |-> 32'(cur_lin) == (ROWS - 1) * COLUMNS)
        else $error("A scrolled result does not leave the cursor at the bottom row start.");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCROLL |-> 32'(r_sweep) < CELLS - COLUMNS)
        else $error("Scroll move ran past the last source row.");

    a_value_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_mode != MODE_READ |-> r_value == '0)
        else $error("A non-read word carries a cell value.");
`endif

endmodule
